// File: hw/rtl/quadratic_probe_hash_table_assert.svh
// assertion macros for the quadratic probe hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// property checked on every clock edge outside reset
`define QPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define QPHT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/qpht_pkg.sv
// shared constants for the quadratic probe hash table
`default_nettype none

package qpht_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned KeyWidthDefault = 32;

  // fixed field widths
  localparam int unsigned KeyInW   = 32;
  localparam int unsigned CmdW     = 1;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned MinTableSize   = 5;
  localparam int unsigned TableSizeReset = 1021;

  // remainder unit retires this many dividend bits per cycle
  localparam int unsigned ModBitsPerCycle = 4;

  localparam logic [CmdW-1:0] CmdFind   = 1'b0;
  localparam logic [CmdW-1:0] CmdInsert = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/qpht_mod.sv
// multi-cycle remainder unit: dividend mod divisor, a few bits per cycle
`default_nettype none

module qpht_mod
  import qpht_pkg::*;
#(
  parameter int unsigned SizeW = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [KeyInW-1:0] dividend_i,
  input  wire logic [SizeW-1:0]  divisor_i,
  output logic                   done_o,
  output logic [SizeW-1:0]       rem_o
);

  localparam int unsigned Steps = KeyInW / ModBitsPerCycle;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyInW-1:0] dq_q, dq_d;
  logic [SizeW-1:0]  dv_q, dv_d;
  logic [SizeW-1:0]  rem_q, rem_d;
  logic [SizeW-1:0]  rem_step;

  // restoring remainder, one compare and subtract per dividend bit
  always_comb begin
    logic [SizeW:0] t;
    rem_step = rem_q;
    for (int j = 0; j < ModBitsPerCycle; j++) begin
      t = {rem_step, dq_q[KeyInW-1-j]};
      if (t >= {1'b0, dv_q}) begin
        t = t - {1'b0, dv_q};
      end
      rem_step = t[SizeW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps);
      dq_d   = dividend_i;
      dv_d   = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_step;
      dq_d  = dq_q << ModBitsPerCycle;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/qpht_mem.sv
// slot store: occupied flag and key per slot, with a clearing sweep after reset
`default_nettype none

module qpht_mem
  import qpht_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault,
  parameter int unsigned WordW    = KeyWidthDefault + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(Capacity)-1:0] rd_addr_i,
  output logic      [WordW-1:0]            rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(Capacity)-1:0] wr_addr_i,
  input  wire logic [WordW-1:0]            wr_data_i,
  output logic                             ready_o
);

  localparam int unsigned AddrW = $clog2(Capacity);

  logic [WordW-1:0] mem [Capacity];
  logic [WordW-1:0] rd_data_q;
  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordW-1:0] wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Capacity - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // the sweep writes an empty word: all zero, so the occupied flag on top is clear
  assign we    = clr_q || wr_en_i;
  assign waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_q;

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_probe_hash_table.sv
// top level of the quadratic probe hash table
//
//  channel   direction  tdata                                       tuser
//  s_axis    in         key[31:0]                                   command[0]
//  m_axis    out        slot[9:0] found[10] inserted[11] full[12]   -
//  cfg       in         table_size[10:0]                            -
//
// an item is accepted, its home slot is computed (8 remainder steps, then the done flag),
// each probe takes a memory read, then a compare, and the result is posted once the output
// register is free; an item makes at most table size probes
// after reset a clearing pass writes every slot empty, with no item taken
// a finished result waits in the output register while the next item is taken
`default_nettype none
`include "quadratic_probe_hash_table_assert.svh"

module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDefault,
  parameter int unsigned KEY_WIDTH = KeyWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [KeyInW-1:0]   s_axis_tdata_i,  // key
  input  wire logic [CmdW-1:0]     s_axis_tuser_i,  // command
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [OutDataW-1:0] m_axis_tdata_o,  // slot, found, inserted, full_res
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgW-1:0]     cfg_data_i       // table_size
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned SizeW = $clog2(CAPACITY + 1);
  localparam int unsigned WordW = KEY_WIDTH + 1;
  localparam logic [63:0] KeyMask =
    (KEY_WIDTH >= 64) ? '1 : ((64'd1 << KEY_WIDTH) - 64'd1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      cfg_q;
  logic [SizeW-1:0]     eff_size;
  logic [SizeW-1:0]     size_q, size_d;
  logic [CmdW-1:0]      cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [SizeW-1:0]     pos_q, pos_d;
  logic [SizeW-1:0]     inc_q, inc_d;
  logic [SizeW-1:0]     cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic                 ins_q, ins_d;
  logic                 full_q, full_d;
  logic                 out_valid_q, out_valid_d;
  logic [OutDataW-1:0]  out_data_q, out_data_d;

  logic [63:0]          key_ext;
  logic                 in_acc;
  logic                 mod_done;
  logic [SizeW-1:0]     mod_rem;
  logic                 mem_ready;
  logic                 mem_rd_en;
  logic [WordW-1:0]     mem_rd_data;
  logic                 mem_wr_en;
  logic                 hit_empty, hit_key, at_limit;
  logic [SizeW:0]       pos_sum, inc_sum;
  logic [SizeW-1:0]     pos_nxt, inc_nxt;
  logic                 out_free;
  logic [63:0]          pos_ext;

  // config register; the user must write it only while no item is in flight, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(TableSizeReset);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (32'(cfg_q) < MinTableSize) begin
      eff_size = SizeW'(MinTableSize);
    end else if (32'(cfg_q) > CAPACITY) begin
      eff_size = SizeW'(CAPACITY);
    end else begin
      eff_size = SizeW'(cfg_q);
    end
  end

  assign key_ext         = {32'b0, s_axis_tdata_i} & KeyMask;
  assign s_axis_tready_o = (state_q == S_IDLE) && mem_ready;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  qpht_mod #(
    .SizeW (SizeW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (key_ext[KeyInW-1:0]),
    .divisor_i  (eff_size),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  qpht_mem #(
    .Capacity (CAPACITY),
    .WordW    (WordW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (pos_q[AddrW-1:0]),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (pos_q[AddrW-1:0]),
    .wr_data_i ({1'b1, key_q}),
    .ready_o   (mem_ready)
  );

  assign hit_empty = !mem_rd_data[WordW-1];
  assign hit_key   = mem_rd_data[WordW-1] && (mem_rd_data[KEY_WIDTH-1:0] == key_q);
  assign at_limit  = (cnt_q == size_q);

  // next probe position and increment, each reduced below the size
  assign pos_sum = {1'b0, pos_q} + {1'b0, inc_q};
  assign pos_nxt = (pos_sum >= {1'b0, size_q}) ? SizeW'(pos_sum - {1'b0, size_q})
                                               : pos_sum[SizeW-1:0];
  assign inc_sum = {1'b0, inc_q} + (SizeW + 1)'(2);
  assign inc_nxt = (inc_sum >= {1'b0, size_q}) ? SizeW'(inc_sum - {1'b0, size_q})
                                               : inc_sum[SizeW-1:0];

  assign mem_rd_en = (state_q == S_PROBE);
  assign mem_wr_en = (state_q == S_CHECK) && hit_empty && (cmd_q == CmdInsert);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign pos_ext   = {{(64 - SizeW){1'b0}}, pos_q};

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    inc_d       = inc_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    ins_d       = ins_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          size_d  = eff_size;
          cmd_d   = s_axis_tuser_i;
          key_d   = key_ext[KEY_WIDTH-1:0];
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          pos_d   = mod_rem;
          inc_d   = SizeW'(1);
          cnt_d   = SizeW'(1);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (hit_empty || hit_key || at_limit) begin
          found_d = !hit_empty && hit_key;
          ins_d   = hit_empty && (cmd_q == CmdInsert);
          full_d  = !hit_empty && !hit_key;
          state_d = S_DONE;
        end else begin
          pos_d   = pos_nxt;
          inc_d   = inc_nxt;
          cnt_d   = cnt_q + SizeW'(1);
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OutDataW'({full_q, ins_q, found_q, pos_ext[SlotW-1:0]});
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    inc_q      <= inc_d;
    cnt_q      <= cnt_d;
    found_q    <= found_d;
    ins_q      <= ins_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `QPHT_ASSERT(a_home_in_range, !mod_done || (mod_rem < size_q), "home slot not below size")
  `QPHT_ASSERT(a_probe_in_range, !(state_q == S_CHECK) || ((pos_q < size_q) && (inc_q < size_q) && (cnt_q != '0) && (cnt_q <= size_q)), "probe state out of range")
  `QPHT_ASSERT(a_result_flags, !m_axis_tvalid_o || ($countones(m_axis_tdata_o[SlotW+2:SlotW]) <= 1), "more than one result flag set")
  `QPHT_ASSERT(a_no_item_in_clear, !s_axis_tready_o || mem_ready, "item taken during clearing pass")
  `QPHT_ASSERT_NEXT(a_result_posted, (state_q == S_DONE) && out_free, m_axis_tvalid_o && (state_q == S_IDLE), "result not posted")

endmodule

`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the quadratic probe hash table
`timescale 1ns / 100ps

module tb;
  import qpht_pkg::*;

  localparam int unsigned Slots = CapacityDefault;
  localparam int unsigned MaxStall = 64;
  // clearing pass plus ~500 items, each at worst a full probe sweep and long stalls, taken 4x
  localparam int unsigned CycleLimit = 4 * (Slots + 500 * (16 + 2 * Slots + 2 * MaxStall));

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  typedef struct packed {
    logic             full;
    logic             inserted;
    logic             found;
    logic [SlotW-1:0] slot;
  } probe_res_t;

  typedef struct packed {
    row_kind_e       kind;
    logic [CfgW-1:0] size;
    logic [CmdW-1:0] cmd;
    logic [31:0]     key;
    logic            typed;
    probe_res_t      res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [KeyInW-1:0]   s_axis_tdata_i;   // key[31:0]
  logic [CmdW-1:0]     s_axis_tuser_i;   // command[0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;   // slot[9:0] found[10] inserted[11] full_res[12]
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;       // table_size[10:0]

  quadratic_probe_hash_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // shadow of the table as the block should hold it
  logic [CfgW-1:0] table_size_q;
  bit              slot_used [Slots];
  logic [31:0]     slot_key [Slots];

  probe_res_t  pending_results [$];
  logic [31:0] stored_keys [$];
  stim_row_t   directed_rows [$];

  int unsigned src_idle_pct, dst_idle_pct;
  int unsigned errs, n_items, n_results, n_hits, n_inserts, n_full, n_cfg;
  int unsigned cycles;

  probe_res_t got, want;

  function automatic int unsigned live_slots();
    if (table_size_q < MinTableSize) return MinTableSize;
    if (table_size_q > Slots) return Slots;
    return table_size_q;
  endfunction

  // walks the probe sequence home + i*i and applies an insert to the shadow table
  function automatic probe_res_t probe_table(logic [CmdW-1:0] cmd, logic [31:0] key);
    int unsigned span, pos, step;
    bit stop, hit, done;
    probe_res_t r;
    span = live_slots();
    pos  = key % span;
    step = 1;
    stop = 1'b0;
    hit  = 1'b0;
    done = 1'b0;
    while (!done) begin
      if (!slot_used[pos]) begin
        stop = 1'b1;
        done = 1'b1;
      end else if (slot_key[pos] == key) begin
        stop = 1'b1;
        hit  = 1'b1;
        done = 1'b1;
      end else if (step == span) begin
        done = 1'b1;
      end else begin
        pos = (pos + 2 * step - 1) % span;
        step++;
      end
    end
    r.slot     = pos[SlotW-1:0];
    r.found    = hit;
    r.inserted = stop && !hit && (cmd == CmdInsert);
    r.full     = !stop;
    if (r.inserted) begin
      slot_used[pos] = 1'b1;
      slot_key[pos]  = key;
    end
    return r;
  endfunction

  function automatic void add_row(row_kind_e kind, logic [CfgW-1:0] size, logic [CmdW-1:0] cmd,
                                  logic [31:0] key, logic typed, logic [SlotW-1:0] slot,
                                  logic found, logic inserted, logic full);
    stim_row_t row;
    row.kind         = kind;
    row.size         = size;
    row.cmd          = cmd;
    row.key          = key;
    row.typed        = typed;
    row.res.slot     = slot;
    row.res.found    = found;
    row.res.inserted = inserted;
    row.res.full     = full;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(logic [CmdW-1:0] cmd, logic [31:0] key, logic typed,
                           probe_res_t typed_res);
    probe_res_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = key;
    s_axis_tuser_i  = cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = probe_table(cmd, key);
    if (pred.inserted) begin
      stored_keys.push_back(key);
      if (stored_keys.size() > 128) void'(stored_keys.pop_front());
    end
    pending_results.push_back(typed ? typed_res : pred);
    n_items++;
  endtask

  // table_size may only change while nothing is in flight
  task automatic write_size(logic [CfgW-1:0] size);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = size;
    do @(posedge clk_i); while (!cfg_ready_o);
    table_size_q = size;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[12:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: slot=%0d found=%b ins=%b full=%b",
                 $time, got.slot, got.found, got.inserted, got.full);
        errs++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (got.slot !== want.slot || got.found !== want.found ||
            got.inserted !== want.inserted || got.full !== want.full) begin
          $display("%0t: mismatch exp slot=%0d found=%b ins=%b full=%b, got slot=%0d found=%b ins=%b full=%b",
                   $time, want.slot, want.found, want.inserted, want.full,
                   got.slot, got.found, got.inserted, got.full);
          errs++;
        end
        if (got.found) n_hits++;
        if (got.inserted) n_inserts++;
        if (got.full) n_full++;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned span, pick, home;
    longint unsigned wide_key;
    logic [31:0] key;
    logic [CmdW-1:0] cmd;
    logic [CfgW-1:0] size;
    probe_res_t none;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CmdFind;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    src_idle_pct    = 17;
    dst_idle_pct    = 71;
    errs = 0; n_items = 0; n_results = 0; n_hits = 0; n_inserts = 0; n_full = 0; n_cfg = 0;
    none = '0;
    table_size_q = TableSizeReset;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    foreach (slot_key[i]) slot_key[i] = '0;

    // directed part: reset size first, then clamped and extreme sizes
    add_row(RowItem, 0, CmdFind,   32'd0,          1, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd0,          1, 10'd0,    0, 1, 0);
    add_row(RowItem, 0, CmdInsert, 32'd0,          1, 10'd0,    1, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd0,          1, 10'd0,    1, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd1021,       1, 10'd1,    0, 1, 0);
    add_row(RowItem, 0, CmdInsert, 32'd2042,       1, 10'd4,    0, 1, 0);
    add_row(RowItem, 0, CmdInsert, 32'hFFFF_FFFF,  0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd3063,       0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'h8000_0000,  0, 10'd0,    0, 0, 0);
    // below the minimum: clamps to five slots, the three probed slots are taken
    add_row(RowCfg,  11'd0, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd0,          0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd5,          0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd10,         0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd2,          0, 10'd0,    0, 0, 0);
    // above the capacity: clamps to the full store
    add_row(RowCfg,  11'd2047, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'd1023,       1, 10'd1023, 0, 1, 0);
    add_row(RowItem, 0, CmdInsert, 32'd2047,       0, 10'd0,    0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'hFFFF_FFFF,  0, 10'd0,    0, 0, 0);
    add_row(RowCfg,  11'd4, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd4,          0, 10'd0,    0, 0, 0);
    add_row(RowCfg,  11'd1025, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd1023,       0, 10'd0,    0, 0, 0);
    add_row(RowCfg,  11'd5, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdInsert, 32'hFFFF_FFFF,  0, 10'd0,    0, 0, 0);
    add_row(RowCfg,  11'd1024, CmdFind, 0, 0, 0, 0, 0, 0);
    add_row(RowItem, 0, CmdFind,   32'd0,          0, 10'd0,    0, 0, 0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == RowCfg) begin
        write_size(directed_rows[r].size);
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].typed,
                  directed_rows[r].res);
      end
    end

    // random part: one table size per phase, idling pattern changes by thirds
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       size = 11'd5;
        1:       size = 11'd1021;
        2:       size = 11'd7;
        3:       size = 11'd2047;
        4:       size = 11'd13;
        5:       size = 11'd0;
        6:       size = 11'd251;
        7:       size = 11'd1025;
        8:       size = 11'd31;
        9:       size = 11'd4;
        10:      size = 11'd1024;
        default: size = 11'($urandom_range(0, 2047));
      endcase
      if (p < 4) begin
        src_idle_pct = 17;
        dst_idle_pct = 71;
      end else if (p < 8) begin
        src_idle_pct = 71;
        dst_idle_pct = 17;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      write_size(size);
      span = live_slots();
      for (int n = 0; n < 36; n++) begin
        cmd  = ($urandom_range(99) < 60) ? CmdInsert : CmdFind;
        pick = $urandom_range(99);
        if (pick < 30 && stored_keys.size() != 0) begin
          // key seen before: hits and inserts of a present key
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end else if (pick < 60) begin
          // keys that mostly share home slots 0, 1 and span - 1 build long probe chains
          case ($urandom_range(3))
            0:       home = 0;
            1:       home = 1;
            2:       home = span - 1;
            default: home = $urandom_range(0, span - 1);
          endcase
          wide_key = longint'($urandom_range(0, 4000000)) * span + home;
          key = wide_key[31:0];
        end else if (pick < 85) begin
          key = $urandom;
        end else begin
          case ($urandom_range(4))
            0:       key = 32'd0;
            1:       key = 32'hFFFF_FFFF;
            2:       key = 32'h8000_0000;
            3:       key = span - 1;
            default: key = span;
          endcase
        end
        send_item(cmd, key, 1'b0, none);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // any stray result would show up within one worst-case probe sweep
    repeat (2 * Slots + 16) @(posedge clk_i);

    $display("%0d transactions over %0d table sizes (reset, clamped low and high, primes)",
             n_items, n_cfg + 1);
    $display("%0d results: %0d hits, %0d inserts, %0d probe limit", n_results, n_hits,
             n_inserts, n_full);
    if (errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
